// File: rtl/qslerp_pkg.sv
// Shared types, constants and arctangent steps for the quaternion slerp pipeline.
`default_nettype none

package qslerp_pkg;

   // Default fraction width of the quaternion components.
   localparam int FRACTION_BITS_DEF = 14;

   // Iteration counts of the pipelined units, and the CORDIC word width.
   localparam int ROUNDS    = 24;
   localparam int ROOT_BITS = 31;
   localparam int QUO_BITS  = 41;
   localparam int CW        = 34;

   // Path codes reported with every result.
   localparam logic [1:0] PATH_INTERP = 2'd0;
   localparam logic [1:0] PATH_FIRST  = 2'd1;
   localparam logic [1:0] PATH_MID    = 2'd2;

   typedef logic signed [CW-1:0] cord_word_type;
   typedef logic signed [15:0] comp_type;

   typedef struct packed {
      comp_type w;
      comp_type x;
      comp_type y;
      comp_type z;
   } quat_type;

   typedef struct packed {
      cord_word_type x;
      cord_word_type y;
      cord_word_type z;
   } cordic_type;

   typedef struct packed {
      logic [60:0] rem;
      logic [30:0] res;
   } root_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [40:0] quo;
      logic [30:0] num;
      logic        neg;
   } div_type;

   // Per-transaction data that travels beside the arithmetic.
   typedef struct packed {
      quat_type    qa;
      quat_type    qb;
      logic [16:0] blend;
      logic [1:0]  path;
      logic        dot_neg;
      logic [30:0] cos_mag;
      logic [30:0] root;
   } side_type;

   typedef struct packed {
      quat_type   q;
      logic [1:0] path;
   } result_type;

   // Angles use pi = 2^30; Q30 gain compensation for the rotation units.
   localparam cord_word_type CORD_QUARTER = 34'sd536870912;
   localparam cord_word_type CORD_GAIN    = 34'sd652032874;
   localparam logic [30:0]   HALF_TURN    = 31'd1073741824;
   localparam logic [16:0]   BLEND_ONE    = 17'd65536;
   // Largest root whose product with 1000 stays below 2^30.
   localparam logic [30:0]   SMALL_ROOT_MAX = 31'd1073741;

   localparam logic [28:0] ARC_TABLE [ROUNDS] = '{
      29'd268435456, 29'd158466703, 29'd83729454, 29'd42502378, 29'd21333666,
      29'd10677233, 29'd5339919, 29'd2670123, 29'd1335082, 29'd667543,
      29'd333772, 29'd166886, 29'd83443, 29'd41722, 29'd20861, 29'd10430,
      29'd5215, 29'd2608, 29'd1304, 29'd652, 29'd326, 29'd163, 29'd81, 29'd41
   };

endpackage

`default_nettype wire

// File: rtl/qslerp_root_cell.sv
// One bit of the pipelined integer square root.
`default_nettype none

module qslerp_root_cell #(
   parameter int BIT = 0
) (
   input  wire                  clock,
   input  wire                  en,
   input  qslerp_pkg::root_type d_in,
   output qslerp_pkg::root_type d_out
);
   import qslerp_pkg::*;

   root_type    stage_ff;
   root_type    stage_in;
   logic [62:0] trial;

   // Try to set this bit of the root against the running remainder.
   always_comb begin
      trial    = (63'(d_in.res) << (BIT + 1)) + (63'd1 << (2 * BIT));
      stage_in = d_in;
      if ({2'b00, d_in.rem} >= trial) begin
         stage_in.rem = d_in.rem - trial[60:0];
         stage_in.res = d_in.res | (31'd1 << BIT);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign d_out = stage_ff;

endmodule

`default_nettype wire

// File: rtl/qslerp_cordic_cell.sv
// One micro-rotation of a pipelined CORDIC, in vectoring or rotation mode.
`default_nettype none

module qslerp_cordic_cell #(
   parameter int STEP      = 0,
   parameter bit VECTORING = 1'b0
) (
   input  wire                    clock,
   input  wire                    en,
   input  qslerp_pkg::cordic_type d_in,
   output qslerp_pkg::cordic_type d_out
);
   import qslerp_pkg::*;

   cordic_type    stage_ff;
   cordic_type    stage_in;
   cord_word_type sx;
   cord_word_type sy;
   cord_word_type arc;
   logic          ccw;

   // Vectoring drives y toward zero; rotation drives z toward zero.
   always_comb begin
      sx  = d_in.x >>> STEP;
      sy  = d_in.y >>> STEP;
      arc = cord_word_type'(ARC_TABLE[STEP]);
      ccw = VECTORING ? !(d_in.y > 0) : (d_in.z >= 0);
      if (ccw) begin
         stage_in.x = d_in.x - sy;
         stage_in.y = d_in.y + sx;
         stage_in.z = d_in.z - arc;
      end else begin
         stage_in.x = d_in.x + sy;
         stage_in.y = d_in.y - sx;
         stage_in.z = d_in.z + arc;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign d_out = stage_ff;

endmodule

`default_nettype wire

// File: rtl/qslerp_div_cell.sv
// One quotient bit of the pipelined restoring divider.
`default_nettype none

module qslerp_div_cell #(
   parameter int BIT = 0
) (
   input  wire                 clock,
   input  wire                 en,
   input  wire [30:0]          divisor,
   input  qslerp_pkg::div_type d_in,
   output qslerp_pkg::div_type d_out
);
   import qslerp_pkg::*;

   div_type     stage_ff;
   div_type     stage_in;
   logic        bit_in;
   logic [31:0] trial;

   // The dividend is the numerator shifted up by 30, so low bits are zero.
   if (BIT >= 30) begin : g_num_bit
      assign bit_in = d_in.num[BIT-30];
   end else begin : g_zero_bit
      assign bit_in = 1'b0;
   end

   // Bring down one dividend bit and subtract the divisor where it fits.
   always_comb begin
      trial    = {d_in.rem[30:0], bit_in};
      stage_in = d_in;
      stage_in.rem = trial;
      if (trial >= {1'b0, divisor}) begin
         stage_in.rem      = trial - {1'b0, divisor};
         stage_in.quo[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign d_out = stage_ff;

endmodule

`default_nettype wire

// File: rtl/quaternion_slerp.sv
// Top level of the fixed-point quaternion slerp pipeline.
//
//  channel | direction | tdata                                   | tuser
//  req     | in        | first_w..z, second_w..z, blend_t        | -
//  rsp     | out       | out_w, out_x, out_y, out_z              | path_code
//
// One transaction enters per cycle while the skid register is empty. The chain
// is made of 31 square-root bits, 24 vectoring steps, 24 rotation steps and
// 41 divider bits, plus the multiply stages and the output register.
// Reset clears the valid bits of the chain and of the output buffer.
// When the result side stalls, a skid register absorbs one more result, and
// the whole chain holds while that register is full.
`default_nettype none

module quaternion_slerp #(
   parameter int FRACTION_BITS = qslerp_pkg::FRACTION_BITS_DEF
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // first_w, first_x, first_y, first_z, second_w, second_x, second_y,
   // second_z, blend_t, zero fill
   input  wire [151:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // out_w, out_x, out_y, out_z
   output logic [63:0] rsp_tdata,
   // path_code
   output logic [1:0]  rsp_tuser
);
   import qslerp_pkg::*;

   // Stage positions along the chain.
   localparam int ST_PROD   = 0;
   localparam int ST_DOT    = 1;
   localparam int ST_SQ     = 2;
   localparam int ST_RAD    = 3;
   localparam int ST_ROOT   = 4;
   localparam int ST_VINIT  = ST_ROOT + ROOT_BITS;
   localparam int ST_VEC    = ST_VINIT + 1;
   localparam int ST_ACLAMP = ST_VEC + ROUNDS;
   localparam int ST_AMUL   = ST_ACLAMP + 1;
   localparam int ST_RINIT  = ST_AMUL + 1;
   localparam int ST_ROT    = ST_RINIT + 1;
   localparam int ST_DINIT  = ST_ROT + ROUNDS;
   localparam int ST_DIV    = ST_DINIT + 1;
   localparam int ST_WPROD  = ST_DIV + QUO_BITS;
   localparam int ST_FIN    = ST_WPROD + 1;
   localparam int NSTAGE    = ST_FIN + 1;

   // Shift that brings the squared fraction width to Q30.
   localparam int SH_R = (2 * FRACTION_BITS > 30) ? (2 * FRACTION_BITS - 30) : 0;
   localparam int SH_L = (2 * FRACTION_BITS > 30) ? 0 : (30 - 2 * FRACTION_BITS);

   logic                advance;
   logic [NSTAGE-1:0]   valid_ff;
   side_type            side_ff [NSTAGE];
   side_type            side_in [NSTAGE];

   logic signed [31:0]  prod_ff [4];
   logic signed [31:0]  prod_in [4];
   comp_type            ain [4];
   comp_type            bin [4];

   logic signed [33:0]  dot;
   logic [33:0]         mag;
   logic [63:0]         m30;
   logic                first_hit;

   logic [61:0]         sq_ff;
   logic [61:0]         rad_full;
   logic [60:0]         rad_ff;

   root_type            root_link [ROOT_BITS+1];
   cordic_type          vinit_ff;
   cordic_type          vinit_in;
   cordic_type          vec_link [ROUNDS+1];

   logic [30:0]         ang_ff;
   logic [30:0]         ang_in;
   logic [16:0]         tc_ff;
   logic [16:0]         tc_in;
   logic [47:0]         amul_ff;
   logic [30:0]         ang_b_ff;
   logic [30:0]         part_t;
   logic [30:0]         part_rest;

   cordic_type          rinit_r_ff;
   cordic_type          rinit_t_ff;
   cordic_type          rot_r_link [ROUNDS+1];
   cordic_type          rot_t_link [ROUNDS+1];

   div_type             dinit_r_ff;
   div_type             dinit_t_ff;
   div_type             div_r_link [QUO_BITS+1];
   div_type             div_t_link [QUO_BITS+1];

   logic signed [41:0]  wr1;
   logic signed [41:0]  wr2;
   logic signed [57:0]  wa_ff [4];
   logic signed [57:0]  wb_ff [4];
   comp_type            qa_arr [4];
   comp_type            qb_arr [4];

   quat_type            fin_ff;
   quat_type            fin_in;
   comp_type            blend_val [4];
   comp_type            mid_val [4];
   logic signed [58:0]  wsum [4];
   logic signed [28:0]  wshift [4];
   logic signed [16:0]  msum [4];

   result_type          arrive_res;
   result_type          out_ff;
   result_type          skid_ff;
   logic                out_vld_ff;
   logic                skid_vld_ff;
   logic                take;
   logic                arrive;

   // Rotation start point for an angle in [0, pi].
   function automatic cordic_type rot_start(input logic [30:0] phi);
      cordic_type r;
      if ({3'b000, phi} > CORD_QUARTER) begin
         r.x = '0;
         r.y = CORD_GAIN;
         r.z = cord_word_type'({3'b000, phi}) - CORD_QUARTER;
      end else begin
         r.x = CORD_GAIN;
         r.y = '0;
         r.z = cord_word_type'({3'b000, phi});
      end
      return r;
   endfunction

   // Divider start point from a sine value.
   function automatic div_type div_start(input cord_word_type y);
      div_type       d;
      cord_word_type a;
      a     = y[CW-1] ? -y : y;
      d.neg = y[CW-1];
      d.num = a[30:0];
      d.rem = {12'd0, a[30:11]};
      d.quo = '0;
      return d;
   endfunction

   // Signed weight from a divider result.
   function automatic logic signed [41:0] weight_of(input div_type d);
      logic signed [41:0] q;
      q = $signed({1'b0, d.quo});
      return d.neg ? -q : q;
   endfunction

   // Saturate a shifted weighted sum to 16 bits.
   function automatic comp_type sat16(input logic signed [28:0] v);
      comp_type r;
      if (v > 29'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -29'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   assign advance    = !skid_vld_ff;
   assign req_tready = advance;

   // Unpack the request and form the four component products.
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         ain[k]     = comp_type'(req_tdata[16*k +: 16]);
         bin[k]     = comp_type'(req_tdata[64 + 16*k +: 16]);
         prod_in[k] = ain[k] * bin[k];
      end
   end

   // Dot product, its magnitude in Q30 and the first-returned test.
   always_comb begin
      dot = 34'(prod_ff[0]) + 34'(prod_ff[1]) + 34'(prod_ff[2]) + 34'(prod_ff[3]);
      mag = dot[33] ? 34'(-dot) : 34'(dot);
      first_hit = {30'd0, mag} >= (64'd1 << (2 * FRACTION_BITS));
      m30 = (64'(mag) >> SH_R) << SH_L;
   end

   // Side data along the chain, with the stages that add to it.
   always_comb begin
      side_in[0].qa      = '{w: ain[0], x: ain[1], y: ain[2], z: ain[3]};
      side_in[0].qb      = '{w: bin[0], x: bin[1], y: bin[2], z: bin[3]};
      side_in[0].blend   = req_tdata[144:128];
      side_in[0].path    = PATH_INTERP;
      side_in[0].dot_neg = 1'b0;
      side_in[0].cos_mag = '0;
      side_in[0].root    = '0;
      for (int n = 1; n < NSTAGE; n++) begin
         side_in[n] = side_ff[n-1];
      end
      side_in[ST_DOT].path    = first_hit ? PATH_FIRST : PATH_INTERP;
      side_in[ST_DOT].dot_neg = dot[33];
      side_in[ST_DOT].cos_mag = m30[30:0];
      side_in[ST_VINIT].root  = root_link[ROOT_BITS].res;
      if (side_ff[ST_VINIT-1].path == PATH_INTERP &&
          root_link[ROOT_BITS].res <= SMALL_ROOT_MAX) begin
         side_in[ST_VINIT].path = PATH_MID;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NSTAGE-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int n = 0; n < NSTAGE; n++) begin
            side_ff[n] <= side_in[n];
         end
      end
   end

   // Radicand 2^60 - c^2 for the sine.
   assign rad_full = (62'd1 << 60) - sq_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= prod_in[k];
         end
         sq_ff  <= 62'(side_ff[ST_DOT].cos_mag) * 62'(side_ff[ST_DOT].cos_mag);
         rad_ff <= rad_full[60:0];
      end
   end

   // Square root chain.
   assign root_link[0] = '{rem: rad_ff, res: '0};

   for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
      qslerp_root_cell #(
         .BIT(ROOT_BITS - 1 - j)
      ) u_root (
         .clock(clock),
         .en   (advance),
         .d_in (root_link[j]),
         .d_out(root_link[j+1])
      );
   end

   // Start of the half-angle search from (c, s).
   always_comb begin
      if (side_ff[ST_VINIT-1].dot_neg) begin
         vinit_in.x = cord_word_type'({3'b000, root_link[ROOT_BITS].res});
         vinit_in.y = cord_word_type'({3'b000, side_ff[ST_VINIT-1].cos_mag});
         vinit_in.z = CORD_QUARTER;
      end else begin
         vinit_in.x = cord_word_type'({3'b000, side_ff[ST_VINIT-1].cos_mag});
         vinit_in.y = cord_word_type'({3'b000, root_link[ROOT_BITS].res});
         vinit_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vinit_ff <= vinit_in;
      end
   end

   assign vec_link[0] = vinit_ff;

   for (genvar j = 0; j < ROUNDS; j++) begin : g_vec
      qslerp_cordic_cell #(
         .STEP     (j),
         .VECTORING(1'b1)
      ) u_vec (
         .clock(clock),
         .en   (advance),
         .d_in (vec_link[j]),
         .d_out(vec_link[j+1])
      );
   end

   // Clamp the half-angle and the blend factor.
   always_comb begin
      if (vec_link[ROUNDS].z < 0) begin
         ang_in = '0;
      end else if (vec_link[ROUNDS].z > cord_word_type'({3'b000, HALF_TURN})) begin
         ang_in = HALF_TURN;
      end else begin
         ang_in = vec_link[ROUNDS].z[30:0];
      end
      tc_in = (side_ff[ST_ACLAMP-1].blend > BLEND_ONE) ? BLEND_ONE
                                                       : side_ff[ST_ACLAMP-1].blend;
   end

   // Split the angle into t*angle and the rest.
   assign part_t    = amul_ff[46:16];
   assign part_rest = ang_b_ff - part_t;

   always_ff @(posedge clock) begin
      if (advance) begin
         ang_ff     <= ang_in;
         tc_ff      <= tc_in;
         amul_ff    <= 48'(ang_ff) * 48'(tc_ff) + 48'd32768;
         ang_b_ff   <= ang_ff;
         rinit_r_ff <= rot_start(part_rest);
         rinit_t_ff <= rot_start(part_t);
      end
   end

   assign rot_r_link[0] = rinit_r_ff;
   assign rot_t_link[0] = rinit_t_ff;

   for (genvar j = 0; j < ROUNDS; j++) begin : g_rot
      qslerp_cordic_cell #(
         .STEP     (j),
         .VECTORING(1'b0)
      ) u_rot_r (
         .clock(clock),
         .en   (advance),
         .d_in (rot_r_link[j]),
         .d_out(rot_r_link[j+1])
      );
      qslerp_cordic_cell #(
         .STEP     (j),
         .VECTORING(1'b0)
      ) u_rot_t (
         .clock(clock),
         .en   (advance),
         .d_in (rot_t_link[j]),
         .d_out(rot_t_link[j+1])
      );
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dinit_r_ff <= div_start(rot_r_link[ROUNDS].y);
         dinit_t_ff <= div_start(rot_t_link[ROUNDS].y);
      end
   end

   // Weight division: sine * 2^30 / s, one quotient bit per stage.
   assign div_r_link[0] = dinit_r_ff;
   assign div_t_link[0] = dinit_t_ff;

   for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
      qslerp_div_cell #(
         .BIT(QUO_BITS - 1 - j)
      ) u_div_r (
         .clock  (clock),
         .en     (advance),
         .divisor(side_ff[ST_DIV+j-1].root),
         .d_in   (div_r_link[j]),
         .d_out  (div_r_link[j+1])
      );
      qslerp_div_cell #(
         .BIT(QUO_BITS - 1 - j)
      ) u_div_t (
         .clock  (clock),
         .en     (advance),
         .divisor(side_ff[ST_DIV+j-1].root),
         .d_in   (div_t_link[j]),
         .d_out  (div_t_link[j+1])
      );
   end

   // Weighted component products.
   always_comb begin
      wr1 = weight_of(div_r_link[QUO_BITS]);
      wr2 = weight_of(div_t_link[QUO_BITS]);
      qa_arr[0] = side_ff[ST_WPROD-1].qa.w;
      qa_arr[1] = side_ff[ST_WPROD-1].qa.x;
      qa_arr[2] = side_ff[ST_WPROD-1].qa.y;
      qa_arr[3] = side_ff[ST_WPROD-1].qa.z;
      qb_arr[0] = side_ff[ST_WPROD-1].qb.w;
      qb_arr[1] = side_ff[ST_WPROD-1].qb.x;
      qb_arr[2] = side_ff[ST_WPROD-1].qb.y;
      qb_arr[3] = side_ff[ST_WPROD-1].qb.z;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < 4; k++) begin
            wa_ff[k] <= qa_arr[k] * wr1;
            wb_ff[k] <= qb_arr[k] * wr2;
         end
      end
   end

   // Round, saturate and choose the result by path.
   always_comb begin
      msum[0] = 17'(side_ff[ST_FIN-1].qa.w) + 17'(side_ff[ST_FIN-1].qb.w);
      msum[1] = 17'(side_ff[ST_FIN-1].qa.x) + 17'(side_ff[ST_FIN-1].qb.x);
      msum[2] = 17'(side_ff[ST_FIN-1].qa.y) + 17'(side_ff[ST_FIN-1].qb.y);
      msum[3] = 17'(side_ff[ST_FIN-1].qa.z) + 17'(side_ff[ST_FIN-1].qb.z);
      for (int k = 0; k < 4; k++) begin
         wsum[k]      = 59'(wa_ff[k]) + 59'(wb_ff[k]) + 59'sd536870912;
         wshift[k]    = 29'(wsum[k] >>> 30);
         blend_val[k] = sat16(wshift[k]);
         mid_val[k]   = comp_type'(msum[k] >>> 1);
      end
      unique case (side_ff[ST_FIN-1].path)
         PATH_FIRST: begin
            fin_in = side_ff[ST_FIN-1].qa;
         end
         PATH_MID: begin
            fin_in = '{w: mid_val[0], x: mid_val[1], y: mid_val[2], z: mid_val[3]};
         end
         default: begin
            fin_in = '{w: blend_val[0], x: blend_val[1], y: blend_val[2],
                       z: blend_val[3]};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fin_ff <= fin_in;
      end
   end

   // Output register with one skid entry.
   assign take       = out_vld_ff && rsp_tready;
   assign arrive     = advance && valid_ff[NSTAGE-1];
   assign arrive_res = '{q: fin_ff, path: side_ff[ST_FIN].path};

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (take) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (arrive) begin
         if (!out_vld_ff || take) begin
            out_vld_ff <= 1'b1;
         end else begin
            skid_vld_ff <= 1'b1;
         end
      end else if (take) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (arrive) begin
         if (!out_vld_ff || take) begin
            out_ff <= arrive_res;
         end else begin
            skid_ff <= arrive_res;
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {out_ff.q.z, out_ff.q.y, out_ff.q.x, out_ff.q.w};
   assign rsp_tuser  = out_ff.path;

endmodule

`default_nettype wire

// File: rtl/qslerp_checker.sv
// Port-level checks of the quaternion slerp top level, attached by bind.
`default_nettype none

module qslerp_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [63:0] rsp_tdata,
   input wire [1:0]  rsp_tuser
);

   // A stalled result transaction keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // No result is shown right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // The request side only stalls when a result is waiting on the other side.
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("request stalled with no result pending");

   // A skid entry waiting implies the output holds until taken.
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      !req_tready && !rsp_tready |=> !req_tready && rsp_tvalid)
      else $error("skid entry lost while stalled");

   // Reported path is one of the three defined cases.
   a_path_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("undefined path code");

endmodule

bind quaternion_slerp qslerp_checker u_qslerp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tuser (rsp_tuser)
);

`default_nettype wire
